### design/rtbe_pkg.sv
// Shared constants, types and control codes for the ranging timing budget encoder.
package rtbe_pkg;

  localparam int OSC_W     = 16;
  localparam int BUD_W     = 20;
  localparam int PER_W     = 6;
  localparam int CODE_W    = 16;
  localparam int OUT_BUD_W = 32;
  localparam int PLL_W     = 31;
  localparam int M9_W      = 34;
  localparam int MACRO_W   = 37;
  localparam int RUS_W     = 19;
  localparam int QUO_W     = 17;
  localparam int LANE_LAT  = QUO_W + 3;
  localparam int DEC_LAT   = 3;
  localparam int DEC_PAD   = LANE_LAT - 1 - DEC_LAT;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 96;

  localparam logic [OSC_W-1:0] OSC_RESET = 16'd48000;
  localparam longint unsigned PLL_NUM = 64'd1 << (PLL_W - 1);
  localparam logic [M9_W-1:0] M9_RESET = M9_W'(9 * (PLL_NUM / 64'(OSC_RESET)));

  localparam logic [BUD_W-1:0]     MIN_BUDGET = 20'd20000;
  localparam logic [RUS_W-1:0]     HALF_GUARD = 19'd2264;
  localparam logic [OUT_BUD_W-1:0] GUARD_US   = 32'd4528;
  localparam logic [11:0]          ROUND_HALF = 12'h800;
  localparam logic [30:0]          SAT_THR    = 31'd2147481383;
  localparam logic [OUT_BUD_W-1:0] SAT_VALUE  = 32'hFFFF_FFFF;
  localparam logic [7:0]           EXP_LIMIT  = 8'd32;

  // The macro period never drops below 18432 fraction units, so one
  // microsecond always rounds to zero macro clocks and encodes as zero.
  localparam logic [CODE_W-1:0] MM_CODE = '0;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    PLL_IDLE,
    PLL_DIV,
    PLL_SCALE
  } pll_state_t;

  typedef struct packed {
    logic valid;
    logic op;
    logic err;
  } ctrl_t;

endpackage

### design/rtbe_pll.sv
// Oscillator register and serial divider that derive the scaled PLL period.
module rtbe_pll
  import rtbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [OSC_W-1:0]  cfg_wdata,
  output logic [M9_W-1:0]   m9,
  output logic              busy
);

  pll_state_t state, state_next;
  logic [4:0]       cnt;
  logic [OSC_W-1:0] dvs;
  logic [OSC_W-1:0] rem;
  logic [PLL_W-1:0] quo;
  logic [OSC_W:0]   shifted;
  logic             ge;

  always_comb begin
    state_next = state;
    unique case (state)
      PLL_IDLE:  state_next = PLL_IDLE;
      PLL_DIV:   if (cnt == 5'd0) state_next = PLL_SCALE;
      PLL_SCALE: state_next = PLL_IDLE;
      default:   state_next = PLL_IDLE;
    endcase
    if (cfg_we) state_next = PLL_DIV;
  end

  always_comb begin
    busy = (state != PLL_IDLE);
  end

  assign shifted = {rem, (cnt == 5'(PLL_W - 1))};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PLL_IDLE;
      m9    <= M9_RESET;
    end else begin
      state <= state_next;
      if (state == PLL_SCALE) begin
        m9 <= (M9_W'(quo) << 3) + M9_W'(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      cnt <= 5'(PLL_W - 1);
      rem <= '0;
      quo <= '0;
      dvs <= (cfg_wdata == '0) ? OSC_W'(1) : cfg_wdata;
    end else if (state == PLL_DIV) begin
      cnt <= cnt - 5'd1;
      rem <= ge ? OSC_W'(shifted - {1'b0, dvs}) : shifted[OSC_W-1:0];
      quo <= {quo[PLL_W-2:0], ge};
    end
  end

endmodule

### design/rtbe_lane.sv
// One lane: macro period, pipelined rounding division and timeout encoding.
module rtbe_lane
  import rtbe_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [PER_W-1:0]   period,
  input  logic [RUS_W-1:0]   range_us,
  input  logic [M9_W-1:0]    m9,
  output logic [MACRO_W-1:0] macro,
  output logic [CODE_W-1:0]  code
);

  localparam int MP_W = M9_W + PER_W + 1;
  localparam int DW   = MACRO_W + QUO_W;

  function automatic logic [CODE_W-1:0] encode_mclks(input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] m;
    logic [7:0]       ex;
    logic [QUO_W-1:0] mant;
    m  = q - QUO_W'(1);
    ex = '0;
    for (int b = 8; b < QUO_W; b++) begin
      if (m[b]) ex = 8'(b - 7);
    end
    mant = m >> ex;
    encode_mclks = (q == '0) ? '0 : {ex, mant[7:0]};
  endfunction

  logic [PER_W:0]     p1;
  logic [MP_W-1:0]    mprod;
  logic [RUS_W-1:0]   rus;
  logic [MACRO_W-1:0] rem [0:QUO_W];
  logic [MACRO_W-1:0] dvs [0:QUO_W];
  logic [QUO_W-1:0]   quo [0:QUO_W];
  logic [DW-1:0]      dsh [0:QUO_W-1];
  logic [MACRO_W-1:0] rem_next [0:QUO_W-1];
  logic [QUO_W-1:0]   ge;

  assign p1    = {1'b0, period} + (PER_W + 1)'(1);
  assign mprod = MP_W'(m9) * MP_W'(p1);

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      dsh[k]      = DW'(dvs[k]) << (QUO_W - 1 - k);
      ge[k]       = (DW'(rem[k]) >= dsh[k]);
      rem_next[k] = ge[k] ? (rem[k] - dsh[k][MACRO_W-1:0]) : rem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      macro  <= mprod[MACRO_W+2:3];
      rus    <= range_us;
      rem[0] <= MACRO_W'({rus, 12'b0}) + (macro >> 1);
      dvs[0] <= macro;
      quo[0] <= '0;
      for (int k = 0; k < QUO_W; k++) begin
        rem[k+1] <= rem_next[k];
        dvs[k+1] <= dvs[k];
        quo[k+1] <= {quo[k][QUO_W-2:0], ge[k]};
      end
      code <= encode_mclks(quo[QUO_W]);
    end
  end

endmodule

### design/rtbe_decode.sv
// Decoder that turns a range timeout word back into a budget, saturating.
module rtbe_decode
  import rtbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [MACRO_W-1:0]   macro,
  input  logic [CODE_W-1:0]    word,
  output logic [OUT_BUD_W-1:0] budget
);

  localparam int PROD_W = MACRO_W + 8;
  localparam int FULL_W = PROD_W + 32;
  localparam int US_W   = FULL_W - 12;

  logic [PROD_W-1:0]  prod;
  logic [4:0]         ex5;
  logic [MACRO_W-1:0] macro_d;
  logic               sat0;
  logic               sat1;
  logic [FULL_W-1:0]  full;
  logic [US_W-1:0]    us;
  logic               sat;

  assign us  = full[FULL_W-1:12];
  assign sat = sat1 || (|us[US_W-1:31]) || (us[30:0] > SAT_THR);

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= PROD_W'(word[7:0]) * PROD_W'(macro);
      ex5     <= word[12:8];
      macro_d <= macro;
      sat0    <= (word[7:0] != '0) && (word[15:8] >= EXP_LIMIT);
      full    <= (FULL_W'(prod) << ex5) + FULL_W'(macro_d) + FULL_W'(ROUND_HALF);
      sat1    <= sat0;
      budget  <= sat ? SAT_VALUE : (OUT_BUD_W'({us[30:0], 1'b0}) + GUARD_US);
    end
  end

endmodule

### design/rtbe_merge.sv
// Merging stage that aligns the decoded budget and builds the output register.
module rtbe_merge
  import rtbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctrl_t                ctl,
  input  logic [CODE_W-1:0]    code_a,
  input  logic [CODE_W-1:0]    code_b,
  input  logic [OUT_BUD_W-1:0] dec_budget,
  output logic                 m_tvalid,
  output logic [M_DATA_W-1:0]  m_tdata,
  output logic [0:0]           m_tuser
);

  logic [OUT_BUD_W-1:0] pad [0:DEC_PAD-1];
  logic [M_DATA_W-1:0]  data_next;
  logic                 err_next;

  always_comb begin
    data_next = '0;
    err_next  = 1'b0;
    priority if (ctl.op == OP_DECODE) begin
      data_next = {pad[DEC_PAD-1], {4{CODE_W'(0)}}};
    end else if (ctl.err) begin
      err_next = 1'b1;
    end else begin
      data_next = {OUT_BUD_W'(0), code_b, MM_CODE, code_a, MM_CODE};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pad[0] <= dec_budget;
      for (int k = 1; k < DEC_PAD; k++) begin
        pad[k] <= pad[k-1];
      end
      m_tdata    <= data_next;
      m_tuser[0] <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl.valid;
    end
  end

endmodule

### design/ranging_timing_budget_encoder.sv
// Top level of the ranging timing budget encoder: input stage, two lanes, decoder and merge.
//
//  channel | direction | handshake         | content
//  s_*     | in        | s_tvalid/s_tready | tdata budget, periods, word; tuser op
//  m_*     | out       | m_tvalid/m_tready | tdata four timeouts, budget; tuser error
//  cfg_*   | in        | cfg_we            | oscillator frequency word
//
// One word is accepted per cycle while the output is not stalled and the PLL divider is idle.
// The pipeline depth is set mainly by the 17 one-bit stages of the rounding divider in each lane.
// After a configuration write the serial PLL divider keeps s_tready low until m9 is updated.
// A stalled output freezes the whole pipeline and holds s_tready low.
// Reset is synchronous and restores the oscillator frequency of 48000.
module ranging_timing_budget_encoder
  import rtbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [OSC_W-1:0]    cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // budget, period A code, period B code, encoded timeout word
  input  logic [S_DATA_W-1:0] s_tdata,
  // op
  input  logic [0:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // mm_timeout_a, range_timeout_a, mm_timeout_b, range_timeout_b, budget_out_us
  output logic [M_DATA_W-1:0] m_tdata,
  // error
  output logic [0:0]          m_tuser
);

  logic                 adv;
  logic                 busy;
  logic [M9_W-1:0]      m9;
  logic                 v1;
  logic                 op1;
  logic [BUD_W-1:0]     budget1;
  logic [PER_W-1:0]     pa1;
  logic [PER_W-1:0]     pb1;
  logic [CODE_W-1:0]    word1;
  logic [CODE_W-1:0]    word2;
  logic [RUS_W-1:0]     range_us;
  ctrl_t                ctl [0:LANE_LAT-1];
  logic [MACRO_W-1:0]   macro_a;
  logic [MACRO_W-1:0]   macro_b;
  logic [CODE_W-1:0]    code_a;
  logic [CODE_W-1:0]    code_b;
  logic [OUT_BUD_W-1:0] dec_budget;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv & ~busy;
  assign range_us = budget1[BUD_W-1:1] - HALF_GUARD;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      for (int k = 0; k < LANE_LAT; k++) begin
        ctl[k] <= '0;
      end
    end else if (adv) begin
      v1     <= s_tvalid & s_tready;
      ctl[0] <= '{valid: v1, op: op1, err: (budget1 < MIN_BUDGET)};
      for (int k = 1; k < LANE_LAT; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1     <= s_tuser[0];
      budget1 <= s_tdata[BUD_W-1:0];
      pa1     <= s_tdata[BUD_W+PER_W-1:BUD_W];
      pb1     <= s_tdata[BUD_W+2*PER_W-1:BUD_W+PER_W];
      word1   <= s_tdata[BUD_W+2*PER_W+CODE_W-1:BUD_W+2*PER_W];
      word2   <= word1;
    end
  end

  rtbe_pll u_pll (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m9        (m9),
    .busy      (busy)
  );

  rtbe_lane u_lane_a (
    .clk      (clk),
    .en       (adv),
    .period   (pa1),
    .range_us (range_us),
    .m9       (m9),
    .macro    (macro_a),
    .code     (code_a)
  );

  rtbe_lane u_lane_b (
    .clk      (clk),
    .en       (adv),
    .period   (pb1),
    .range_us (range_us),
    .m9       (m9),
    .macro    (macro_b),
    .code     (code_b)
  );

  rtbe_decode u_decode (
    .clk    (clk),
    .en     (adv),
    .macro  (macro_a),
    .word   (word2),
    .budget (dec_budget)
  );

  rtbe_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .ctl        (ctl[LANE_LAT-1]),
    .code_a     (code_a),
    .code_b     (code_b),
    .dec_budget (dec_budget),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

### design/rtbe_checker.sv
// Port-level checks for the ranging timing budget encoder and their binding.
module rtbe_checker
  import rtbe_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_we,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [0:0]          m_tuser
);

  // A stalled output word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // An error word carries no timeouts and no budget.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error word carries nonzero data");

  // A word holds either encoded range timeouts or a decoded budget, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[95:64] == '0) ||
                 (m_tdata[31:16] == '0 && m_tdata[63:48] == '0))
    else $error("word mixes timeouts and budget");

  // A new oscillator frequency blocks input while the PLL period is recomputed.
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input accepted during PLL period update");

endmodule

bind ranging_timing_budget_encoder rtbe_checker u_rtbe_checker (.*);
